@@ rtl/core/acit_pkg.sv @@
// ----------------------------------------------------------------------------
// acit_pkg: shared types and constants for the AVI chunk index table
// Field widths, operation and status codes, and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package acit_pkg;

    localparam int DEFAULT_VIDEO_ENTRIES = 4096;
    localparam int DEFAULT_AUDIO_ENTRIES = 4096;

    localparam int OP_W     = 2;
    localparam int TAG_W    = 8;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 3;
    localparam int NUMBER_W = 12;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 112;

    // operation codes (s_tuser)
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_SEEK   = 2'd1;
    localparam logic [OP_W-1:0] OP_KEY    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // result status codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_VIDEO_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_AUDIO_STORED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SEEK_DONE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_AUDIO     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_KEY_FOUND    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NONE         = 3'd7;

    // chunk id characters
    localparam logic [TAG_W-1:0] TAG_D = 8'h64;  // 'd'
    localparam logic [TAG_W-1:0] TAG_W_CHAR = 8'h77;  // 'w'
    localparam logic [TAG_W-1:0] TAG_B = 8'h62;  // 'b'

    localparam logic [WORD_W-1:0] SMALL_CHUNK_LIMIT = 32'd1000;
    localparam int KEYFRAME_BIT_POS = 4;

    typedef struct packed {
        logic load;      // latch the input word
        logic exec;      // dispatch: append, clear, or start a search
        logic srch_rd;   // read the audio table at mid (or lo when done)
        logic srch_cmp;  // narrow lo/hi from the read total
        logic srch_fin;  // build the seek result from entry lo
        logic key_rd;    // read the video table at the scan index
        logic key_cmp;   // test the keyframe bit, advance the scan
        logic deliver;   // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            audio_empty;
        logic            key_beyond;
        logic            srch_more;
        logic            key_hit;
        logic            key_last;
        logic            out_free;
    } sts_t;

endpackage

@@ rtl/core/acit_ctrl.sv @@
// ----------------------------------------------------------------------------
// acit_ctrl: sequencing controller for the AVI chunk index table
// Steps one item at a time through dispatch, search loops and delivery.
// ----------------------------------------------------------------------------
module acit_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  acit_pkg::sts_t sts,
    output acit_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_S_RD    = 3'd2;
    localparam logic [2:0] ST_S_CMP   = 3'd3;
    localparam logic [2:0] ST_S_FIN   = 3'd4;
    localparam logic [2:0] ST_K_RD    = 3'd5;
    localparam logic [2:0] ST_K_CMP   = 3'd6;
    localparam logic [2:0] ST_DELIVER = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                case (sts.op)
                    acit_pkg::OP_SEEK:
                        state_next = sts.audio_empty ? ST_DELIVER : ST_S_RD;
                    acit_pkg::OP_KEY:
                        state_next = sts.key_beyond ? ST_DELIVER : ST_K_RD;
                    default:
                        state_next = ST_DELIVER;
                endcase
            end
            ST_S_RD: begin
                cmd.srch_rd = 1'b1;
                state_next  = sts.srch_more ? ST_S_CMP : ST_S_FIN;
            end
            ST_S_CMP: begin
                cmd.srch_cmp = 1'b1;
                state_next   = ST_S_RD;
            end
            ST_S_FIN: begin
                cmd.srch_fin = 1'b1;
                state_next   = ST_DELIVER;
            end
            ST_K_RD: begin
                cmd.key_rd = 1'b1;
                state_next = ST_K_CMP;
            end
            ST_K_CMP: begin
                cmd.key_cmp = 1'b1;
                state_next  = (sts.key_hit || sts.key_last) ? ST_DELIVER : ST_K_RD;
            end
            ST_DELIVER: begin
                if (sts.out_free) begin
                    cmd.deliver = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/acit_datapath.sv @@
// ----------------------------------------------------------------------------
// acit_datapath: tables, counters and search registers
// Holds the video and audio memories, the running audio total, the binary
// search bounds, the keyframe scan index and the output register.
// ----------------------------------------------------------------------------
module acit_datapath #(
    parameter int VIDEO_ENTRIES = acit_pkg::DEFAULT_VIDEO_ENTRIES,
    parameter int AUDIO_ENTRIES = acit_pkg::DEFAULT_AUDIO_ENTRIES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [acit_pkg::WORD_W-1:0]       cfg_wr_data,
    input  logic [acit_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [acit_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [acit_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [acit_pkg::STATUS_W-1:0]     m_tuser,
    input  acit_pkg::cmd_t                    cmd,
    output acit_pkg::sts_t                    sts
);

    localparam int W   = acit_pkg::WORD_W;
    localparam int VCW = $clog2(VIDEO_ENTRIES + 1);
    localparam int ACW = $clog2(AUDIO_ENTRIES + 1);
    localparam int VIW = $clog2(VIDEO_ENTRIES);
    localparam int AIW = $clog2(AUDIO_ENTRIES);

    // configuration
    logic [W-1:0] movi_reg;

    // latched input word
    logic [acit_pkg::OP_W-1:0]  op_reg;
    logic [acit_pkg::TAG_W-1:0] t3_reg;
    logic [acit_pkg::TAG_W-1:0] t4_reg;
    logic                       key_reg;
    logic [W-1:0]               pos_reg;
    logic [W-1:0]               len_reg;
    logic [W-1:0]               seek_reg;

    // table state
    logic [VCW-1:0] vcount_reg;
    logic [ACW-1:0] acount_reg;
    logic [W-1:0]   total_reg;

    // memories: video {key, position}, audio {position, length, start total}
    logic [W:0]     vmem [VIDEO_ENTRIES];
    logic [3*W-1:0] amem [AUDIO_ENTRIES];
    logic [W:0]     vrd_reg;
    logic [3*W-1:0] ard_reg;

    // search registers
    logic [ACW-1:0] lo_reg;
    logic [ACW-1:0] hi_reg;
    logic [ACW-1:0] mid_reg;
    logic [VCW-1:0] f_reg;

    // result and output registers
    logic [acit_pkg::STATUS_W-1:0] res_status_reg;
    logic [acit_pkg::NUMBER_W-1:0] res_num_reg;
    logic [W-1:0]                  res_inbyte_reg;
    logic [W-1:0]                  res_pos_reg;
    logic                          m_valid_reg;
    logic [acit_pkg::STATUS_W-1:0] m_status_reg;
    logic [acit_pkg::NUMBER_W-1:0] m_num_reg;
    logic [W-1:0]                  m_inbyte_reg;
    logic [W-1:0]                  m_pos_reg;
    logic [W-1:0]                  m_total_reg;

    logic           is_video;
    logic           is_audio;
    logic           v_full;
    logic           a_full;
    logic [ACW:0]   mid_sum;
    logic [ACW-1:0] mid;
    logic           srch_more;
    logic [VCW:0]   f_inc;
    logic [W-1:0]   s_seek_raw;
    logic [W-1:0]   ard_pos;
    logic [W-1:0]   ard_len;
    logic [W-1:0]   ard_total;

    assign is_video = (t3_reg == acit_pkg::TAG_D) && (t4_reg == acit_pkg::TAG_B);
    assign is_audio = (t3_reg == acit_pkg::TAG_W_CHAR) && (t4_reg == acit_pkg::TAG_B);
    assign v_full   = (vcount_reg >= VCW'(VIDEO_ENTRIES));
    assign a_full   = (acount_reg >= ACW'(AUDIO_ENTRIES));

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[ACW:1];
    assign srch_more = (({1'b0, lo_reg} + (ACW+1)'(1)) < {1'b0, hi_reg});
    assign f_inc     = {1'b0, f_reg} + (VCW+1)'(1);

    assign s_seek_raw = s_tdata[143:112];
    assign ard_pos    = ard_reg[3*W-1:2*W];
    assign ard_len    = ard_reg[2*W-1:W];
    assign ard_total  = ard_reg[W-1:0];

    assign sts.op          = op_reg;
    assign sts.audio_empty = (acount_reg == '0);
    assign sts.key_beyond  = (seek_reg >= W'(vcount_reg));
    assign sts.srch_more   = srch_more;
    assign sts.key_hit     = vrd_reg[W];
    assign sts.key_last    = (f_inc >= {1'b0, vcount_reg});
    assign sts.out_free    = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'd0, m_total_reg, m_pos_reg, m_inbyte_reg, m_num_reg};

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            movi_reg <= '0;
        end else if (cfg_wr_en) begin
            movi_reg <= cfg_wr_data;
        end
    end

    // input latch; position is formed here, clamp negative seek to zero
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_tuser;
            t3_reg   <= s_tdata[7:0];
            t4_reg   <= s_tdata[15:8];
            key_reg  <= s_tdata[16 + acit_pkg::KEYFRAME_BIT_POS];
            pos_reg  <= s_tdata[79:48] + movi_reg;
            len_reg  <= s_tdata[111:80];
            seek_reg <= s_seek_raw[W-1] ? '0 : s_seek_raw;
        end
    end

    // memory writes
    always_ff @(posedge aclk) begin
        if (cmd.exec && (op_reg == acit_pkg::OP_APPEND) && is_video && !v_full) begin
            vmem[vcount_reg[VIW-1:0]] <= {key_reg, pos_reg};
        end
        if (cmd.exec && (op_reg == acit_pkg::OP_APPEND) && is_audio && !a_full) begin
            amem[acount_reg[AIW-1:0]] <= {pos_reg, len_reg, total_reg};
        end
    end

    // memory reads, registered
    always_ff @(posedge aclk) begin
        if (cmd.key_rd) begin
            vrd_reg <= vmem[f_reg[VIW-1:0]];
        end
        if (cmd.srch_rd) begin
            ard_reg <= amem[srch_more ? mid[AIW-1:0] : lo_reg[AIW-1:0]];
        end
    end

    // counters and running total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= '0;
            acount_reg <= '0;
            total_reg  <= '0;
        end else if (cmd.exec) begin
            unique case (op_reg)
                acit_pkg::OP_APPEND: begin
                    if (is_video && !v_full) begin
                        vcount_reg <= vcount_reg + VCW'(1);
                    end
                    if (is_audio && !a_full) begin
                        acount_reg <= acount_reg + ACW'(1);
                        total_reg  <= total_reg + len_reg;
                    end
                end
                acit_pkg::OP_CLEAR: begin
                    vcount_reg <= '0;
                    acount_reg <= '0;
                    total_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    // search bounds, scan index and result
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_status_reg <= acit_pkg::ST_IGNORED;
            res_num_reg    <= '0;
            res_inbyte_reg <= '0;
            res_pos_reg    <= '0;
            lo_reg         <= '0;
            hi_reg         <= acount_reg;
            f_reg          <= seek_reg[VCW-1:0];
            unique case (op_reg)
                acit_pkg::OP_APPEND: begin
                    if (is_video) begin
                        if (v_full) begin
                            res_status_reg <= acit_pkg::ST_FULL;
                        end else begin
                            res_status_reg <= acit_pkg::ST_VIDEO_STORED;
                            res_num_reg    <= acit_pkg::NUMBER_W'(vcount_reg);
                            res_pos_reg    <= pos_reg;
                        end
                    end else if (is_audio) begin
                        if (a_full) begin
                            res_status_reg <= acit_pkg::ST_FULL;
                        end else begin
                            res_status_reg <= acit_pkg::ST_AUDIO_STORED;
                            res_num_reg    <= acit_pkg::NUMBER_W'(acount_reg);
                            res_pos_reg    <= pos_reg;
                        end
                    end
                end
                acit_pkg::OP_SEEK: begin
                    if (acount_reg == '0) begin
                        res_status_reg <= acit_pkg::ST_NO_AUDIO;
                    end
                end
                acit_pkg::OP_KEY: begin
                    res_status_reg <= acit_pkg::ST_NONE;
                end
                default: ;
            endcase
        end
        if (cmd.srch_rd) begin
            mid_reg <= mid;
        end
        if (cmd.srch_cmp) begin
            if (ard_total > seek_reg) begin
                hi_reg <= mid_reg;
            end else begin
                lo_reg <= mid_reg;
            end
        end
        if (cmd.srch_fin) begin
            res_status_reg <= acit_pkg::ST_SEEK_DONE;
            res_num_reg    <= acit_pkg::NUMBER_W'(lo_reg);
            res_pos_reg    <= ard_pos;
            res_inbyte_reg <= (ard_len > acit_pkg::SMALL_CHUNK_LIMIT) ?
                              (seek_reg - ard_total) : '0;
        end
        if (cmd.key_cmp) begin
            if (vrd_reg[W]) begin
                res_status_reg <= acit_pkg::ST_KEY_FOUND;
                res_num_reg    <= acit_pkg::NUMBER_W'(f_reg);
                res_pos_reg    <= vrd_reg[W-1:0];
            end else begin
                f_reg <= f_inc[VCW-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.deliver) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            m_status_reg <= res_status_reg;
            m_num_reg    <= res_num_reg;
            m_inbyte_reg <= res_inbyte_reg;
            m_pos_reg    <= res_pos_reg;
            m_total_reg  <= total_reg;
        end
    end

endmodule

@@ rtl/core/avi_chunk_index_table_unit.sv @@
// ----------------------------------------------------------------------------
// avi_chunk_index_table_unit: AVI idx1 chunk tables with audio seek and
// keyframe search
// Each s_ word carries one operation in s_tuser (append, audio seek, next
// keyframe search, clear); "db" appends go to the video table, "wb" appends
// to the audio table. Every word yields one m_ result word, status in m_tuser.
// Write movi_offset through cfg_wr_en/cfg_wr_data only while idle.
// Audio seek does one audio memory read per binary search step; keyframe
// search does one video memory read per frame scanned.
// One word in flight: s_tready is high only while the controller idles, so
// the next word is taken only after the result is loaded.
// Reset (aresetn low, synchronous) empties both tables, zeroes the audio
// total and movi_offset, and drops a pending result; table contents stay.
// On a receiver stall, hold the result in the output register; the next word
// is still accepted and worked on, then waits until the register frees.
// ----------------------------------------------------------------------------
module avi_chunk_index_table_unit #(
    parameter int VIDEO_ENTRIES = acit_pkg::DEFAULT_VIDEO_ENTRIES,
    parameter int AUDIO_ENTRIES = acit_pkg::DEFAULT_AUDIO_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // movi_offset register write
    input  logic                           cfg_wr_en,
    input  logic [acit_pkg::WORD_W-1:0]    cfg_wr_data,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tag_third_byte[7:0], tag_fourth_byte[15:8], entry_flags[47:16],
    // entry_offset[79:48], entry_length[111:80], seek_value[143:112]
    input  logic [acit_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [acit_pkg::OP_W-1:0]      s_tuser,
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // chunk_number[11:0], byte_in_chunk[43:12], chunk_position[75:44],
    // audio_total[107:76], zero fill[111:108]
    output logic [acit_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [acit_pkg::STATUS_W-1:0]  m_tuser
);

    acit_pkg::cmd_t cmd;
    acit_pkg::sts_t sts;

    // sequence one word at a time
    acit_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // tables, search registers and output register
    acit_datapath #(
        .VIDEO_ENTRIES (VIDEO_ENTRIES),
        .AUDIO_ENTRIES (AUDIO_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

@@ rtl/core/acit_checker.sv @@
// ----------------------------------------------------------------------------
// acit_checker: port-level checks for the AVI chunk index table
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module acit_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [acit_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [acit_pkg::STATUS_W-1:0]  m_tuser
);

    // hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // empty audio table leaves number, byte and position zero
    a_no_audio_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == acit_pkg::ST_NO_AUDIO) |-> (m_tdata[75:0] == '0))
        else $error("no-audio result carries data");

endmodule

bind avi_chunk_index_table_unit acit_checker u_acit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
